// File: rtl/adsr_geg_pkg.sv
// ----------------------------------------------------------------------------
// adsr_geg_pkg
// shared types, constants and the rate table of the envelope generator
// ----------------------------------------------------------------------------
package adsr_geg_pkg;

    localparam logic [15:0] CNT_RELOAD = 16'h7800;
    localparam logic [10:0] LEVEL_MAX  = 11'h7FF;
    localparam logic [11:0] ATTACK_FAST_STEP = 12'h400;
    localparam logic [11:0] LIN_STEP   = 12'h020;
    localparam logic [11:0] BENT_STEP  = 12'h008;
    localparam logic [11:0] BENT_KNEE  = 12'h600;
    localparam logic [10:0] REL_STEP   = 11'h008;

    localparam logic [1:0] PH_ATTACK  = 2'd0;
    localparam logic [1:0] PH_DECAY   = 2'd1;
    localparam logic [1:0] PH_SUSTAIN = 2'd2;
    localparam logic [1:0] PH_RELEASE = 2'd3;

    localparam logic [1:0] GAIN_LIN_DEC = 2'd0;
    localparam logic [1:0] GAIN_EXP_DEC = 2'd1;
    localparam logic [1:0] GAIN_LIN_INC = 2'd2;
    localparam logic [1:0] GAIN_BENT    = 2'd3;

    localparam logic [1:0] REG_ADSR_FIRST  = 2'd0;
    localparam logic [1:0] REG_ADSR_SECOND = 2'd1;
    localparam logic [1:0] REG_GAIN        = 2'd2;

    typedef struct packed {
        logic [7:0] adsr_first;
        logic [7:0] adsr_second;
        logic [7:0] gain_setting;
    } cfg_t;

    typedef struct packed {
        logic [10:0] level;
        logic [15:0] counter;
        logic [1:0]  phase;
        logic        active;
    } env_state_t;

    typedef struct packed {
        logic        ended;
        logic        active;
        logic [1:0]  phase;
        logic [10:0] level;
    } env_result_t;

    function automatic logic [15:0] rate_lookup(input logic [4:0] idx);
        logic [15:0] r;
        unique case (idx)
            5'd0:  r = 16'h0000;
            5'd1:  r = 16'h000F;
            5'd2:  r = 16'h0014;
            5'd3:  r = 16'h0018;
            5'd4:  r = 16'h001E;
            5'd5:  r = 16'h0028;
            5'd6:  r = 16'h0030;
            5'd7:  r = 16'h003C;
            5'd8:  r = 16'h0050;
            5'd9:  r = 16'h0060;
            5'd10: r = 16'h0078;
            5'd11: r = 16'h00A0;
            5'd12: r = 16'h00C0;
            5'd13: r = 16'h00F0;
            5'd14: r = 16'h0140;
            5'd15: r = 16'h0180;
            5'd16: r = 16'h01E0;
            5'd17: r = 16'h0280;
            5'd18: r = 16'h0300;
            5'd19: r = 16'h03C0;
            5'd20: r = 16'h0500;
            5'd21: r = 16'h0600;
            5'd22: r = 16'h0780;
            5'd23: r = 16'h0A00;
            5'd24: r = 16'h0C00;
            5'd25: r = 16'h0F00;
            5'd26: r = 16'h1400;
            5'd27: r = 16'h1800;
            5'd28: r = 16'h1E00;
            5'd29: r = 16'h2800;
            5'd30: r = 16'h3C00;
            default: r = 16'h7800;
        endcase
        return r;
    endfunction

    // level minus (((level - 1) >> 8) + 1), zero stays zero
    function automatic logic [10:0] exp_step(input logic [10:0] lvl);
        logic [10:0] dm1;
        logic [10:0] dec;
        dm1 = lvl - 11'd1;
        dec = {8'd0, dm1[10:8]} + 11'd1;
        return (lvl == 11'd0) ? 11'd0 : lvl - dec;
    endfunction

endpackage

// File: rtl/adsr_geg_step.sv
// ----------------------------------------------------------------------------
// adsr_geg_step
// next-state and result logic for one sample tick
// ----------------------------------------------------------------------------
module adsr_geg_step
(
    input  adsr_geg_pkg::cfg_t        cfg,
    input  adsr_geg_pkg::env_state_t  cur,
    input  logic                      key_on,
    input  logic                      key_off,
    output adsr_geg_pkg::env_state_t  nxt,
    output adsr_geg_pkg::env_result_t res
);

    adsr_geg_pkg::env_state_t st;
    logic        adsr_mode;
    logic [3:0]  atk;
    logic [7:0]  g;
    logic [4:0]  rate_idx;
    logic        use_cnt;
    logic [16:0] diff;
    logic        expired;
    logic [15:0] cnt_upd;
    logic [11:0] lvl;
    logic [11:0] sus_thr;
    logic [10:0] rel_lvl;
    logic        ended;

    assign adsr_mode = cfg.adsr_first[7];
    assign atk       = cfg.adsr_first[3:0];
    assign g         = cfg.gain_setting;
    assign sus_thr   = {1'b0, ({1'b0, cfg.adsr_second[7:5]} + 4'd1), 7'd0} << 1;

    // key handling
    always_comb
    begin
        st = cur;
        if (key_on && !key_off)
        begin
            st.active  = 1'b1;
            st.level   = 11'd0;
            st.counter = adsr_geg_pkg::CNT_RELOAD;
            st.phase   = adsr_geg_pkg::PH_ATTACK;
        end
        if (key_off && st.active)
            st.phase = adsr_geg_pkg::PH_RELEASE;
    end

    // rate counter select and update
    always_comb
    begin
        rate_idx = g[4:0];
        use_cnt  = 1'b0;
        if (adsr_mode)
        begin
            unique case (st.phase)
                adsr_geg_pkg::PH_ATTACK:
                begin
                    rate_idx = {atk, 1'b1};
                    use_cnt  = (atk != 4'hF);
                end
                adsr_geg_pkg::PH_DECAY:
                begin
                    rate_idx = {1'b1, cfg.adsr_first[6:4], 1'b0};
                    use_cnt  = 1'b1;
                end
                adsr_geg_pkg::PH_SUSTAIN:
                begin
                    rate_idx = cfg.adsr_second[4:0];
                    use_cnt  = 1'b1;
                end
                default:
                begin
                    rate_idx = g[4:0];
                    use_cnt  = 1'b0;
                end
            endcase
        end
        else
        begin
            use_cnt = g[7];
        end
        diff    = {1'b0, st.counter} - {1'b0, adsr_geg_pkg::rate_lookup(rate_idx)};
        expired = diff[16] || (diff == 17'd0);
        cnt_upd = expired ? adsr_geg_pkg::CNT_RELOAD : diff[15:0];
    end

    assign rel_lvl = st.level - adsr_geg_pkg::REL_STEP;

    always_comb
    begin
        nxt   = st;
        ended = 1'b0;
        lvl   = {1'b0, st.level};
        if (st.active)
        begin
            if (st.phase == adsr_geg_pkg::PH_RELEASE)
            begin
                if (st.level <= adsr_geg_pkg::REL_STEP)
                begin
                    nxt.level  = 11'd0;
                    nxt.active = 1'b0;
                    ended      = 1'b1;
                end
                else
                begin
                    nxt.level = rel_lvl;
                end
            end
            else
            begin
                if (use_cnt)
                    nxt.counter = cnt_upd;
                if (adsr_mode)
                begin
                    unique case (st.phase)
                        adsr_geg_pkg::PH_ATTACK:
                        begin
                            if (atk == 4'hF)
                                lvl = lvl + adsr_geg_pkg::ATTACK_FAST_STEP;
                            else if (expired)
                                lvl = lvl + adsr_geg_pkg::LIN_STEP;
                            if (lvl > {1'b0, adsr_geg_pkg::LEVEL_MAX})
                            begin
                                nxt.level = adsr_geg_pkg::LEVEL_MAX;
                                nxt.phase = adsr_geg_pkg::PH_DECAY;
                            end
                            else
                            begin
                                nxt.level = lvl[10:0];
                            end
                        end
                        adsr_geg_pkg::PH_DECAY:
                        begin
                            if (expired)
                                nxt.level = adsr_geg_pkg::exp_step(st.level);
                            if ({1'b0, nxt.level} <= sus_thr)
                                nxt.phase = adsr_geg_pkg::PH_SUSTAIN;
                        end
                        adsr_geg_pkg::PH_SUSTAIN:
                        begin
                            if (expired)
                                nxt.level = adsr_geg_pkg::exp_step(st.level);
                        end
                        default:
                        begin
                            nxt.level = st.level;
                        end
                    endcase
                end
                else if (!g[7])
                begin
                    nxt.level = {g[6:0], 4'd0};
                end
                else if (expired)
                begin
                    case (g[6:5])
                        adsr_geg_pkg::GAIN_LIN_DEC:
                            nxt.level = (lvl < adsr_geg_pkg::LIN_STEP) ? 11'd0
                                      : st.level - adsr_geg_pkg::LIN_STEP[10:0];
                        adsr_geg_pkg::GAIN_EXP_DEC:
                            nxt.level = adsr_geg_pkg::exp_step(st.level);
                        adsr_geg_pkg::GAIN_LIN_INC:
                        begin
                            lvl = lvl + adsr_geg_pkg::LIN_STEP;
                            nxt.level = lvl[11] ? adsr_geg_pkg::LEVEL_MAX : lvl[10:0];
                        end
                        default:
                        begin
                            lvl = lvl + ((lvl < adsr_geg_pkg::BENT_KNEE)
                                  ? adsr_geg_pkg::LIN_STEP : adsr_geg_pkg::BENT_STEP);
                            nxt.level = lvl[11] ? adsr_geg_pkg::LEVEL_MAX : lvl[10:0];
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        res.ended  = ended;
        res.active = nxt.active;
        res.phase  = nxt.phase;
        res.level  = nxt.active ? nxt.level : 11'd0;
    end

endmodule

// File: rtl/adsr_gain_envelope_generator_top.sv
// ----------------------------------------------------------------------------
// adsr_gain_envelope_generator_top
// single-voice adsr / gain envelope generator, one transfer per sample tick
// ----------------------------------------------------------------------------
// Each input transfer carries the key flags for one sample tick and produces
// exactly one output transfer with the envelope level, phase, active and
// ended flags after that tick. The block takes one transfer every clock
// cycle while the output register is empty or being read; the input
// transfer loads the result into the output register. The envelope state
// is updated in the same cycle the input is taken, so consecutive ticks
// chain with no gap, and the output register lets a new tick be taken in
// the cycle the pending result is read. Configuration writes take effect on
// the next tick; the user must see they are made while the block is idle, as the block does not check it.
module adsr_gain_envelope_generator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // key_on, key_off
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // level[10:0], phase[12:11], active, ended
);

    adsr_geg_pkg::cfg_t          cfg_reg;
    adsr_geg_pkg::env_state_t    state_reg;
    adsr_geg_pkg::env_state_t    state_next;
    adsr_geg_pkg::env_result_t   res_next;
    adsr_geg_pkg::env_result_t   res_reg;
    logic                        out_valid_reg;
    logic                        accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                adsr_geg_pkg::REG_ADSR_FIRST:  cfg_reg.adsr_first   <= cfg_data;
                adsr_geg_pkg::REG_ADSR_SECOND: cfg_reg.adsr_second  <= cfg_data;
                adsr_geg_pkg::REG_GAIN:        cfg_reg.gain_setting <= cfg_data;
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    adsr_geg_step u_step
    (
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .key_on  (s_tdata[0]),
        .key_off (s_tdata[1]),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.level   <= 11'd0;
            state_reg.counter <= adsr_geg_pkg::CNT_RELOAD;
            state_reg.phase   <= adsr_geg_pkg::PH_ATTACK;
            state_reg.active  <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg};

endmodule

// File: rtl/adsr_geg_checker.sv
// ----------------------------------------------------------------------------
// adsr_geg_checker
// port-level checks of the envelope generator, bound to the top level
// ----------------------------------------------------------------------------
module adsr_geg_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a finished voice reports level zero and the release phase
    a_ended_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[14] |-> !m_tdata[13] && (m_tdata[10:0] == 11'd0)
                                    && (m_tdata[12:11] == adsr_geg_pkg::PH_RELEASE))
        else $error("ended result with active voice, nonzero level or wrong phase");

    // a silent voice shows level zero
    a_inactive_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[13] |-> (m_tdata[10:0] == 11'd0))
        else $error("inactive voice with nonzero level");

    // empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output result changed while stalled");

endmodule

bind adsr_gain_envelope_generator_top adsr_geg_checker u_adsr_geg_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/adsr_gain_envelope_generator_top_test.sv
// ----------------------------------------------------------------------------
// adsr_gain_envelope_generator_top_test
// self-checking bench for the single-voice adsr / gain envelope generator
// ----------------------------------------------------------------------------
// Drives key-on / key-off sample ticks over the input stream and tracks the
// envelope with its own model of the counter, level, phase and voice flag.
// Every output transfer is checked field by field against the oldest
// predicted tick. Directed ticks walk the adsr phases, direct gain, the four
// gain curves, zero rates and release to silence, then random notes with
// random register settings run under three handshake idling mixes.
// ----------------------------------------------------------------------------
module adsr_gain_envelope_generator_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int RELOAD_VAL   = 30720;
    localparam int LVL_TOP      = 2047;
    localparam int ATTACK_JUMP  = 1024;
    localparam int RAMP_STEP    = 32;
    localparam int BENT_FINE    = 8;
    localparam int KNEE         = 1536;
    localparam int RELEASE_DROP = 8;
    localparam int STALL_LIMIT  = 2000;

    localparam int RATE_STEP [32] = '{
        'h0000, 'h000F, 'h0014, 'h0018, 'h001E, 'h0028, 'h0030, 'h003C,
        'h0050, 'h0060, 'h0078, 'h00A0, 'h00C0, 'h00F0, 'h0140, 'h0180,
        'h01E0, 'h0280, 'h0300, 'h03C0, 'h0500, 'h0600, 'h0780, 'h0A00,
        'h0C00, 'h0F00, 'h1400, 'h1800, 'h1E00, 'h2800, 'h3C00, 'h7800
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // key_on, key_off
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // level[10:0], phase[12:11], active, ended

    // envelope tracking state
    logic [7:0]  reg_adsr_first  = '0;
    logic [7:0]  reg_adsr_second = '0;
    logic [7:0]  reg_gain        = '0;
    int          env_lvl  = 0;
    int          env_cnt  = RELOAD_VAL;
    logic [1:0]  env_ph   = adsr_geg_pkg::PH_ATTACK;
    bit          voice_on = 1'b0;

    adsr_geg_pkg::env_result_t expected_env_q [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int ticks_checked  = 0;
    int live_ticks     = 0;
    int notes_started  = 0;
    int silences       = 0;
    int settings_count = 0;
    int stall_cycles   = 0;

    adsr_gain_envelope_generator_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit counter_expired(input logic [4:0] idx);
        env_cnt -= RATE_STEP[idx];
        if (env_cnt > 0)
            return 1'b0;
        env_cnt = RELOAD_VAL;
        return 1'b1;
    endfunction

    function automatic int exp_fall(input int lvl);
        if (lvl <= 0)
            return 0;
        return lvl - (((lvl - 1) >> 8) + 1);
    endfunction

    function automatic void advance_adsr();
        logic [3:0] atk;
        atk = reg_adsr_first[3:0];
        case (env_ph)
            adsr_geg_pkg::PH_ATTACK:
            begin
                if (atk == 4'hF)
                    env_lvl += ATTACK_JUMP;
                else if (counter_expired({atk, 1'b1}))
                    env_lvl += RAMP_STEP;
                if (env_lvl > LVL_TOP)
                begin
                    env_lvl = LVL_TOP;
                    env_ph  = adsr_geg_pkg::PH_DECAY;
                end
            end
            adsr_geg_pkg::PH_DECAY:
            begin
                if (counter_expired({1'b1, reg_adsr_first[6:4], 1'b0}))
                    env_lvl = exp_fall(env_lvl);
                // sustain threshold checked every tick
                if (env_lvl <= 256 * (int'(reg_adsr_second[7:5]) + 1))
                    env_ph = adsr_geg_pkg::PH_SUSTAIN;
            end
            adsr_geg_pkg::PH_SUSTAIN:
            begin
                if (counter_expired(reg_adsr_second[4:0]))
                    env_lvl = exp_fall(env_lvl);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void advance_gain();
        logic [7:0] g;
        g = reg_gain;
        if (!g[7])
            env_lvl = int'(g) * 16;
        else if (counter_expired(g[4:0]))
        begin
            case (g[6:5])
                adsr_geg_pkg::GAIN_LIN_DEC:
                begin
                    env_lvl -= RAMP_STEP;
                    if (env_lvl < 0)
                        env_lvl = 0;
                end
                adsr_geg_pkg::GAIN_EXP_DEC:
                    env_lvl = exp_fall(env_lvl);
                adsr_geg_pkg::GAIN_LIN_INC:
                begin
                    env_lvl += RAMP_STEP;
                    if (env_lvl > LVL_TOP)
                        env_lvl = LVL_TOP;
                end
                default:
                begin
                    env_lvl += (env_lvl < KNEE) ? RAMP_STEP : BENT_FINE;
                    if (env_lvl > LVL_TOP)
                        env_lvl = LVL_TOP;
                end
            endcase
        end
    endfunction

    function automatic adsr_geg_pkg::env_result_t predict_tick(input bit kon, input bit koff);
        adsr_geg_pkg::env_result_t r;
        bit          ended_now;
        ended_now = 1'b0;
        if (kon && !koff)
        begin
            voice_on = 1'b1;
            env_lvl  = 0;
            env_cnt  = RELOAD_VAL;
            env_ph   = adsr_geg_pkg::PH_ATTACK;
        end
        if (koff && voice_on)
            env_ph = adsr_geg_pkg::PH_RELEASE;
        if (voice_on)
        begin
            if (env_ph == adsr_geg_pkg::PH_RELEASE)
            begin
                env_lvl -= RELEASE_DROP;
                if (env_lvl <= 0)
                begin
                    env_lvl   = 0;
                    voice_on  = 1'b0;
                    ended_now = 1'b1;
                end
            end
            else if (reg_adsr_first[7])
                advance_adsr();
            else
                advance_gain();
        end
        r.level  = voice_on ? env_lvl[10:0] : 11'd0;
        r.phase  = env_ph;
        r.active = voice_on;
        r.ended  = ended_now;
        return r;
    endfunction

    task automatic send_tick(input bit kon, input bit koff);
        bit was_on;
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, koff, kon};
        do
            @(posedge clk);
        while (!s_tready);
        was_on = voice_on;
        expected_env_q.push_back(predict_tick(kon, koff));
        if (kon && !koff)
            notes_started++;
        if (was_on || voice_on)
            live_ticks++;
        if (was_on && !voice_on)
            silences++;
    endtask

    // stop sending and let every pending result drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_env_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            adsr_geg_pkg::REG_ADSR_FIRST:  reg_adsr_first  = val;
            adsr_geg_pkg::REG_ADSR_SECOND: reg_adsr_second = val;
            adsr_geg_pkg::REG_GAIN:        reg_gain        = val;
            default:
            begin
            end
        endcase
        settings_count++;
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
        wait_idle();
        write_reg(idx, val);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] first, input logic [7:0] second,
                                  input logic [7:0] gain);
        wait_idle();
        write_reg(adsr_geg_pkg::REG_ADSR_FIRST, first);
        write_reg(adsr_geg_pkg::REG_ADSR_SECOND, second);
        write_reg(adsr_geg_pkg::REG_GAIN, gain);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input adsr_geg_pkg::env_result_t want,
                                 input adsr_geg_pkg::env_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s: expected lvl %0d ph %0d act %0b end %0b, ",
                     $realtime, what, want.level, want.phase, want.active, want.ended,
                     "got lvl %0d ph %0d act %0b end %0b",
                     got.level, got.phase, got.active, got.ended);
    endtask

    // result side: random stall and field check of each transfer
    always @(posedge clk)
    begin
        adsr_geg_pkg::env_result_t got;
        adsr_geg_pkg::env_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = adsr_geg_pkg::env_result_t'(m_tdata[14:0]);
            if (expected_env_q.size() == 0)
                note_mismatch("result with no tick pending", '0, got);
            else
            begin
                want = expected_env_q.pop_front();
                ticks_checked++;
                if (got.level !== want.level || got.phase !== want.phase ||
                    got.active !== want.active || got.ended !== want.ended)
                    note_mismatch("envelope mismatch", want, got);
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] no transfer for %0d cycles", $realtime, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic test_inactive_voice();
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
    endtask

    task automatic test_adsr_phases();
        // fast attack, fastest decay, top sustain level, zero sustain rate
        apply_settings(8'hFF, 8'hE0, 8'h00);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
    endtask

    task automatic test_gain_modes();
        apply_settings(8'h00, 8'h1F, 8'h01);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        set_reg(adsr_geg_pkg::REG_GAIN, 8'h7F);
        send_tick(1'b1, 1'b0);
        set_reg(adsr_geg_pkg::REG_GAIN, 8'hFF);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        set_reg(adsr_geg_pkg::REG_GAIN, 8'h9F);
        send_tick(1'b0, 1'b0);
        set_reg(adsr_geg_pkg::REG_GAIN, 8'hBF);
        send_tick(1'b0, 1'b0);
        set_reg(adsr_geg_pkg::REG_GAIN, 8'hDF);
        send_tick(1'b0, 1'b0);
        set_reg(adsr_geg_pkg::REG_GAIN, 8'h80);
        send_tick(1'b0, 1'b0);
        set_reg(adsr_geg_pkg::REG_GAIN, 8'h00);
        send_tick(1'b0, 1'b0);
        // exponential step at zero level
        set_reg(adsr_geg_pkg::REG_GAIN, 8'hBF);
        send_tick(1'b0, 1'b0);
        // write to an unused index must change nothing
        set_reg(REG_UNUSED, 8'hFF);
        send_tick(1'b0, 1'b0);
        set_reg(adsr_geg_pkg::REG_GAIN, 8'h01);
        send_tick(1'b0, 1'b0);
        set_reg(adsr_geg_pkg::REG_GAIN, 8'h9F);
        send_tick(1'b0, 1'b0);
    endtask

    task automatic play_random_note();
        logic [7:0] first;
        int         hold_len;
        int         tail_len;
        int         pick;
        bit         to_silence;
        first = 8'($urandom_range(255));
        first[7] = ($urandom_range(9) < 6);
        if ($urandom_range(1) == 0)
            first[3:0] = 4'hF;
        apply_settings(first, 8'($urandom_range(255)), 8'($urandom_range(255)));
        send_tick(1'b1, 1'b0);
        hold_len = $urandom_range(30, 2);
        repeat (hold_len)
        begin
            pick = $urandom_range(99);
            if (pick < 90)
                send_tick(1'b0, 1'b0);
            else if (pick < 94)
                send_tick(1'b1, 1'b0);
            else if (pick < 97)
                send_tick(1'b0, 1'b1);
            else
                send_tick(1'b1, 1'b1);
        end
        send_tick(1'b0, 1'b1);
        to_silence = ($urandom_range(5) == 0);
        tail_len = $urandom_range(30, 1);
        while (voice_on && (to_silence || tail_len > 0))
        begin
            send_tick(1'b0, ($urandom_range(3) == 0));
            tail_len--;
        end
        if ($urandom_range(4) == 0)
            send_tick(1'b0, 1'($urandom_range(1)));
    endtask

    task automatic test_random_notes(input int src_pct, input int sink_pct, input int quota);
        int goal;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        goal = live_ticks + quota;
        while (live_ticks < goal)
            play_random_note();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= adsr_geg_pkg::REG_ADSR_FIRST;
        cfg_data  <= 8'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        m_tready  <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct   = 19;
        sink_stall_pct = 56;
        test_inactive_voice();
        test_adsr_phases();
        test_gain_modes();

        test_random_notes(19, 56, 250);
        test_random_notes(56, 19, 250);
        test_random_notes(0, 0, 250);

        wait_idle();
        repeat (3) @(posedge clk);
        $display("notes started %0d, ticks checked %0d, releases to silence %0d, writes %0d",
                 notes_started, ticks_checked, silences, settings_count);
        $display("adsr attack/decay/sustain/release, direct gain and four gain curves, "
                 , "under three stall mixes");
        if (mismatch_count == 0 && expected_env_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
rtl/adsr_geg_pkg.sv
rtl/adsr_geg_step.sv
rtl/adsr_gain_envelope_generator_top.sv
rtl/adsr_geg_checker.sv
tb/sv/adsr_gain_envelope_generator_top_test.sv
